@@ design/bsfr_pkg.sv @@
// Shared types, sizes, codes and pointer helpers for the byte-stuffed frame receiver.
// Depends on nothing; all other files but bsfr_ram refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

  // Storage sizes.
  localparam int RING_BYTES   = 32;
  localparam int PACKET_SLOTS = 8;
  localparam int RING_AW      = $clog2(RING_BYTES);
  localparam int SLOT_AW      = $clog2(PACKET_SLOTS);

  // Field widths of the request and response channels.
  localparam int REQ_W  = 2;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = 3;
  localparam int CFG_AW = 2;

  // Register reset values.
  localparam logic [DATA_W-1:0] START_RESET  = 8'h7E;
  localparam logic [DATA_W-1:0] ESCAPE_RESET = 8'h7D;
  localparam logic [DATA_W-1:0] ABORT_RESET  = 8'h7F;
  localparam logic [DATA_W-1:0] MASK_RESET   = 8'h20;

  typedef enum logic [REQ_W-1:0] {
    REQ_LINE    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_STATUS  = 2'd3
  } req_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_START  = 2'd0,
    CFG_ESCAPE = 2'd1,
    CFG_ABORT  = 2'd2,
    CFG_MASK   = 2'd3
  } cfg_idx_e;

  // Status of one step, without the popped byte (that comes from the ring RAM later).
  typedef struct packed {
    logic             read_valid;
    logic [LEN_W-1:0] packet_length;
    logic [CNT_W-1:0] packets_ready;
  } step_t;

  // One complete response.
  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic              read_valid;
    logic [LEN_W-1:0]  packet_length;
    logic [CNT_W-1:0]  packets_ready;
  } rsp_t;

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] v);
    ring_inc = (v == RING_AW'(RING_BYTES - 1)) ? '0 : v + 1'b1;
  endfunction

  // (a - b) modulo the ring size, for a and b below it.
  function automatic logic [RING_AW-1:0] ring_dist(input logic [RING_AW-1:0] a,
                                                   input logic [RING_AW-1:0] b);
    ring_dist = (a >= b) ? a - b : RING_AW'(RING_BYTES) + a - b;
  endfunction

  function automatic logic [SLOT_AW-1:0] slot_inc(input logic [SLOT_AW-1:0] v);
    slot_inc = (v == SLOT_AW'(PACKET_SLOTS - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [SLOT_AW-1:0] slot_dist(input logic [SLOT_AW-1:0] a,
                                                   input logic [SLOT_AW-1:0] b);
    slot_dist = (a >= b) ? a - b : SLOT_AW'(PACKET_SLOTS) + a - b;
  endfunction

endpackage

`default_nettype wire

@@ design/bsfr_if.sv @@
// Valid/ready channel interfaces for requests and responses of the frame receiver.
// Depends on bsfr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bsfr_req_if;
  logic                             valid;
  logic                             ready;
  logic [bsfr_pkg::REQ_W-1:0]       req_type;
  logic [bsfr_pkg::DATA_W-1:0]      line_byte;
  logic                             line_error;

  modport source (output valid, req_type, line_byte, line_error, input ready);
  modport sink   (input valid, req_type, line_byte, line_error, output ready);
endinterface

interface bsfr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bsfr_pkg::DATA_W-1:0]      read_byte;
  logic                             read_valid;
  logic [bsfr_pkg::LEN_W-1:0]       packet_length;
  logic [bsfr_pkg::CNT_W-1:0]       packets_ready;

  modport source (output valid, read_byte, read_valid, packet_length, packets_ready,
                  input ready);
  modport sink   (input valid, read_byte, read_valid, packet_length, packets_ready,
                  output ready);
endinterface

`default_nettype wire

@@ design/byte_stuffed_frame_receiver.sv @@
// Byte-stuffed frame receiver: a response is staged, then queued. Throughput is one request
// per cycle while the queue has room, set by one ring RAM access and one pointer update per
// step; a two-entry response queue lets one more request in while a response waits.
// Reset (rst_ni, asynchronous, active low) clears pointers, framing flags and the response
// path and loads the default flag, escape, abort and mask bytes; ring contents stay
// undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffed_frame_receiver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  bsfr_req_if.sink                         req,
  bsfr_rsp_if.source                       rsp,
  input  wire logic                        cfg_we_i,
  input  wire logic [bsfr_pkg::CFG_AW-1:0] cfg_idx_i,
  input  wire logic [bsfr_pkg::DATA_W-1:0] cfg_data_i
);

  // Request transfer: the core applies the whole step in this cycle.
  logic                        accept;
  logic                        can_accept;
  bsfr_pkg::step_t             step_res;
  logic [bsfr_pkg::DATA_W-1:0] ring_rdata;

  assign req.ready = can_accept;
  assign accept    = req.valid && req.ready;

  // Core: de-stuffing, packet boundaries and the byte ring. Status is computed from the
  // next-state values so that it describes the state after the step.
  bsfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .req_type_i  (req.req_type),
    .line_byte_i (req.line_byte),
    .line_error_i(req.line_error),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (step_res),
    .rdata_o     (ring_rdata)
  );

  // Response path: register the status during the ring read, then queue it.
  bsfr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .res_i       (step_res),
    .rdata_i     (ring_rdata),
    .can_accept_o(can_accept),
    .rsp         (rsp)
  );

  // A response without a popped byte carries a zero byte.
  a_no_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.read_valid |-> rsp.read_byte == '0)
    else $error("response without a popped byte carries a nonzero byte");

  // With no packet held the reported length is zero.
  a_len_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.packets_ready == '0) |-> rsp.packet_length == '0)
    else $error("nonzero packet length with no packet held");

  // A transfer into an empty response path shows up after the staging and queue registers.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !rsp.valid |-> ##2 rsp.valid)
    else $error("response missing two cycles after transfer");

endmodule

`default_nettype wire

@@ design/bsfr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/bsfr_core.sv @@
// De-stuffing engine: config registers, packet pointers, boundary slots and the byte ring RAM.
// Depends on bsfr_pkg and bsfr_ram.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [bsfr_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [bsfr_pkg::DATA_W-1:0]   line_byte_i,
  input  wire logic                          line_error_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bsfr_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire logic [bsfr_pkg::DATA_W-1:0]   cfg_data_i,
  output bsfr_pkg::step_t                    res_o,
  output logic      [bsfr_pkg::DATA_W-1:0]   rdata_o
);

  localparam int RAW = bsfr_pkg::RING_AW;
  localparam int SAW = bsfr_pkg::SLOT_AW;

  logic [bsfr_pkg::DATA_W-1:0] start_q, escape_q, abort_q, mask_q;

  logic [SAW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [RAW-1:0] rd_ptr_q, rd_ptr_d;         // read position in the oldest packet
  logic [RAW-1:0] oldest_end_q, oldest_end_d; // end of the oldest packet
  logic [RAW-1:0] asm_start_q, asm_start_d;   // start of the packet being assembled
  logic [RAW-1:0] asm_end_q, asm_end_d;       // next free ring entry
  logic           in_frame_q, in_frame_d;
  logic           esc_q, esc_d;

  // Starts of closed packets; only slots two and more past the oldest are read.
  logic [RAW-1:0] bnd_q [bsfr_pkg::PACKET_SLOTS];
  logic           bnd_we;

  logic [SAW-1:0]              nh, nnh, rp2;
  logic                        empty, ring_full;
  logic [RAW-1:0]              cur_start;
  logic [bsfr_pkg::DATA_W-1:0] data_byte;
  logic                        ring_we, ring_re, read_valid;
  logic [RAW-1:0]              len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= bsfr_pkg::START_RESET;
      escape_q <= bsfr_pkg::ESCAPE_RESET;
      abort_q  <= bsfr_pkg::ABORT_RESET;
      mask_q   <= bsfr_pkg::MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (bsfr_pkg::cfg_idx_e'(cfg_idx_i))
        bsfr_pkg::CFG_START:  start_q  <= cfg_data_i;
        bsfr_pkg::CFG_ESCAPE: escape_q <= cfg_data_i;
        bsfr_pkg::CFG_ABORT:  abort_q  <= cfg_data_i;
        bsfr_pkg::CFG_MASK:   mask_q   <= cfg_data_i;
      endcase
    end
  end

  assign nh        = bsfr_pkg::slot_inc(wp_q);
  assign nnh       = bsfr_pkg::slot_inc(nh);
  assign rp2       = bsfr_pkg::slot_inc(bsfr_pkg::slot_inc(rp_q));
  assign empty     = (rp_q == wp_q);
  assign cur_start = empty ? asm_start_q : rd_ptr_q;
  assign ring_full = (bsfr_pkg::ring_inc(asm_end_q) == cur_start);
  assign data_byte = esc_q ? (line_byte_i ^ mask_q) : line_byte_i;

  always_comb begin
    wp_d         = wp_q;
    rp_d         = rp_q;
    rd_ptr_d     = rd_ptr_q;
    oldest_end_d = oldest_end_q;
    asm_start_d  = asm_start_q;
    asm_end_d    = asm_end_q;
    in_frame_d   = in_frame_q;
    esc_d        = esc_q;
    bnd_we       = 1'b0;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    read_valid   = 1'b0;
    if (step_i) begin
      unique case (bsfr_pkg::req_e'(req_type_i))
        bsfr_pkg::REQ_LINE: begin
          priority if (line_error_i) begin
            in_frame_d = 1'b0;
            esc_d      = 1'b0;
            asm_end_d  = asm_start_q;
          end else if (line_byte_i == start_q) begin
            in_frame_d = 1'b1;
            esc_d      = 1'b0;
            if (asm_start_q != asm_end_q) begin
              if (nnh == rp_q) begin
                // no free slot: drop the bytes, stay in frame
                asm_end_d = asm_start_q;
              end else begin
                wp_d        = nh;
                bnd_we      = 1'b1;
                asm_start_d = asm_end_q;
                if (empty) begin
                  rd_ptr_d     = asm_start_q;
                  oldest_end_d = asm_end_q;
                end
              end
            end
          end else if (!in_frame_q) begin
            // hunt for a start byte
          end else if (line_byte_i == abort_q) begin
            in_frame_d = 1'b0;
            esc_d      = 1'b0;
            asm_end_d  = asm_start_q;
          end else if (line_byte_i == escape_q) begin
            esc_d = 1'b1;
          end else if (ring_full) begin
            in_frame_d = 1'b0;
            esc_d      = 1'b0;
            asm_end_d  = asm_start_q;
          end else begin
            esc_d     = 1'b0;
            ring_we   = 1'b1;
            asm_end_d = bsfr_pkg::ring_inc(asm_end_q);
          end
        end
        bsfr_pkg::REQ_POP: begin
          if (!empty && (rd_ptr_q != oldest_end_q)) begin
            ring_re    = 1'b1;
            read_valid = 1'b1;
            rd_ptr_d   = bsfr_pkg::ring_inc(rd_ptr_q);
          end
        end
        bsfr_pkg::REQ_RELEASE: begin
          if (!empty) begin
            rp_d         = bsfr_pkg::slot_inc(rp_q);
            rd_ptr_d     = oldest_end_q;
            oldest_end_d = (rp2 == wp_q) ? asm_start_q : bnd_q[rp2];
          end
        end
        bsfr_pkg::REQ_STATUS: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      rp_q         <= '0;
      rd_ptr_q     <= '0;
      oldest_end_q <= '0;
      asm_start_q  <= '0;
      asm_end_q    <= '0;
      in_frame_q   <= 1'b0;
      esc_q        <= 1'b0;
    end else begin
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      rd_ptr_q     <= rd_ptr_d;
      oldest_end_q <= oldest_end_d;
      asm_start_q  <= asm_start_d;
      asm_end_q    <= asm_end_d;
      in_frame_q   <= in_frame_d;
      esc_q        <= esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      bnd_q[nh] <= asm_end_q;
    end
  end

  // Status after the step.
  assign len = (rp_d != wp_d) ? bsfr_pkg::ring_dist(oldest_end_d, rd_ptr_d) : '0;

  assign res_o.read_valid    = read_valid;
  assign res_o.packet_length = bsfr_pkg::LEN_W'(len);
  assign res_o.packets_ready = bsfr_pkg::CNT_W'(bsfr_pkg::slot_dist(wp_d, rp_d));

  bsfr_ram #(
    .WIDTH(bsfr_pkg::DATA_W),
    .DEPTH(bsfr_pkg::RING_BYTES)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(asm_end_q),
    .wdata_i(data_byte),
    .re_i   (ring_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata_o)
  );

endmodule

`default_nettype wire

@@ design/bsfr_outq.sv @@
// Response path: one stage that waits for the ring read data, then a two-entry queue.
// Depends on bsfr_pkg and bsfr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_outq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire bsfr_pkg::step_t             res_i,
  input  wire logic [bsfr_pkg::DATA_W-1:0] rdata_i,
  output logic                             can_accept_o,
  bsfr_rsp_if.source                       rsp
);

  logic            a_valid_q;
  bsfr_pkg::step_t a_res_q;

  bsfr_pkg::rsp_t  entry_q [2];
  bsfr_pkg::rsp_t  push_entry;
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            pop;
  logic [1:0]      occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      a_res_q <= res_i;
    end
  end

  // Ring read data is valid in the cycle after the pop.
  assign push_entry.read_byte     = a_res_q.read_valid ? rdata_i : '0;
  assign push_entry.read_valid    = a_res_q.read_valid;
  assign push_entry.packet_length = a_res_q.packet_length;
  assign push_entry.packets_ready = a_res_q.packets_ready;

  assign pop = (cnt_q != 2'd0) && rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (a_valid_q) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, a_valid_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      entry_q[wr_q] <= push_entry;
    end
  end

  // Queue plus staged item after this cycle's transfer must leave room for a new one.
  assign occ          = cnt_q + {1'b0, a_valid_q} - {1'b0, pop};
  assign can_accept_o = !occ[1];

  assign rsp.valid         = (cnt_q != 2'd0);
  assign rsp.read_byte     = entry_q[rd_q].read_byte;
  assign rsp.read_valid    = entry_q[rd_q].read_valid;
  assign rsp.packet_length = entry_q[rd_q].packet_length;
  assign rsp.packets_ready = entry_q[rd_q].packets_ready;

endmodule

`default_nettype wire
